FILE: rtl/md5ps_pkg.sv
// Shared types, codes and MD5 round constants for the preimage search engine.
// No dependencies; every other file imports this package.
package md5ps_pkg;

   // Item kinds passed from the front end to the hash back end
   localparam logic [1:0] KIND_TEST    = 2'd0;
   localparam logic [1:0] KIND_HELD    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_TESTED    = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [1:0] ST_IDLE      = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] REG_TARGET_HIGH = 3'd0;
   localparam logic [2:0] REG_TARGET_LOW  = 3'd1;
   localparam logic [2:0] REG_CHARS_LOW   = 3'd2;
   localparam logic [2:0] REG_CHARS_HIGH  = 3'd3;
   localparam logic [2:0] REG_ALPHABET    = 3'd4;
   localparam logic [2:0] REG_LIMIT       = 3'd5;
   localparam logic [2:0] REG_START       = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int ROUNDS      = 64;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;     // this test wraps the odometer at the length limit
      logic [4:0]  len;
      logic [63:0] digits;
   } item_type;

   // Rotate amount of round i
   function automatic int md5_shift(input int i);
      return MD5_S[((i / 16) * 4) + (i % 4)];
   endfunction

   // Message word index of round i
   function automatic logic [3:0] md5_index(input int i);
      int g;
      if (i < 16) begin
         g = i;
      end else if (i < 32) begin
         g = 5 * i + 1;
      end else if (i < 48) begin
         g = 3 * i + 5;
      end else begin
         g = 7 * i;
      end
      return 4'(g % 16);
   endfunction

   // Build padded message word g of a candidate of len characters
   function automatic logic [31:0] msg_word(input logic [3:0] g, input logic [4:0] len,
                                            input logic [63:0] digits,
                                            input logic [127:0] chars);
      logic [31:0] w;
      logic [5:0]  p;
      logic [3:0]  d;
      w = '0;
      for (int k = 0; k < 4; k++) begin
         p = {g, 2'(k)};
         d = digits[4 * p[3:0] +: 4];
         if ({1'b0, p} < {2'b00, len}) begin
            w[8 * k +: 8] = chars[8 * d +: 8];
         end else if ({1'b0, p} == {2'b00, len}) begin
            w[8 * k +: 8] = 8'h80;
         end
      end
      if (g == 4'd14) begin
         w = {24'd0, len, 3'b000};
      end
      return w;
   endfunction

endpackage

FILE: rtl/md5_preimage_search.sv
// Top level of the MD5 preimage search engine: configuration registers,
// front end, item queue and hash back end. Uses md5ps_pkg and all md5ps_* modules.
//
//  channel  | ports                                    | accepted when
//  request  | req_push, req_full, req_restart          | req_push && !req_full
//  response | rsp_pop, rsp_empty, rsp_status/cand_*    | rsp_pop && !rsp_empty
//  csr      | csr_we, csr_index, csr_wdata             | csr_we
//
// One request per cycle sustained while req_full stays low; the first result passes
// through the queue, the 64-stage round pipeline and the result register.
// Reset clears the odometer to length 1 and all flags; registers take their defaults.
// A held response stalls the round pipeline; the 4-entry queue then fills and raises req_full.
module md5_preimage_search import md5ps_pkg::*; #(
   parameter int MAX_LEN     = 16,
   parameter int MAX_CHARSET = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_restart,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_cand_length,
   output logic [63:0] rsp_cand_digits,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0] target_high_ff, target_low_ff, chars_low_ff, chars_high_ff;
   logic [4:0]  alphabet_ff, limit_ff, start_ff;
   logic        accept, q_empty, q_pop;
   item_type    front_item, head_item;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_high_ff <= '0;
         target_low_ff  <= '0;
         chars_low_ff   <= '0;
         chars_high_ff  <= '0;
         alphabet_ff    <= 5'd16;
         limit_ff       <= 5'd8;
         start_ff       <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET_HIGH: target_high_ff <= csr_wdata;
            REG_TARGET_LOW:  target_low_ff  <= csr_wdata;
            REG_CHARS_LOW:   chars_low_ff   <= csr_wdata;
            REG_CHARS_HIGH:  chars_high_ff  <= csr_wdata;
            REG_ALPHABET:    alphabet_ff    <= csr_wdata[4:0];
            REG_LIMIT:       limit_ff       <= csr_wdata[4:0];
            REG_START:       start_ff       <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign accept = req_push && !req_full;

   md5ps_front #(.MAX_LEN(MAX_LEN), .MAX_CHARSET(MAX_CHARSET)) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .restart       (req_restart),
      .alphabet_size (alphabet_ff),
      .length_limit  (limit_ff),
      .start_length  (start_ff),
      .item          (front_item)
   );

   md5ps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (req_full),
      .empty     (q_empty),
      .head_item (head_item)
   );

   md5ps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (head_item),
      .q_pop           (q_pop),
      .target_high     (target_high_ff),
      .target_low      (target_low_ff),
      .chars           ({chars_high_ff, chars_low_ff}),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_status      (rsp_status),
      .rsp_cand_length (rsp_cand_length),
      .rsp_cand_digits (rsp_cand_digits)
   );

endmodule

FILE: rtl/md5ps_front.sv
// Front end: takes requests, keeps the odometer, length and exhaust flag,
// and classifies each request into an item for the hash back end. Uses md5ps_pkg.
module md5ps_front import md5ps_pkg::*; #(
   parameter int MAX_LEN     = 16,
   parameter int MAX_CHARSET = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       restart,
   input  logic [4:0] alphabet_size,
   input  logic [4:0] length_limit,
   input  logic [4:0] start_length,
   output item_type   item
);

   logic [63:0] digits_ff, digits_in;
   logic [4:0]  len_ff, len_in;
   logic        exh_ff, exh_in;

   logic [4:0]  eff_alpha, eff_limit, eff_start, alpha_m1;
   logic [15:0] wrap, carry;
   logic        all_wrap;

   // Clamp configuration values
   always_comb begin
      eff_alpha = alphabet_size;
      if (eff_alpha == 5'd0) eff_alpha = 5'd1;
      if (eff_alpha > 5'(MAX_CHARSET)) eff_alpha = 5'(MAX_CHARSET);
      eff_limit = length_limit;
      if (eff_limit == 5'd0) eff_limit = 5'd1;
      if (eff_limit > 5'(MAX_LEN)) eff_limit = 5'(MAX_LEN);
      eff_start = start_length;
      if (eff_start == 5'd0) eff_start = 5'd1;
      if (eff_start > eff_limit) eff_start = eff_limit;
      alpha_m1 = eff_alpha - 5'd1;
   end

   // Odometer: last character is least significant
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         wrap[i] = {1'b0, digits_ff[4 * i +: 4]} >= alpha_m1;
      end
      for (int i = 0; i < 16; i++) begin
         carry[i] = 1'b1;
         for (int j = 0; j < 16; j++) begin
            if (j > i && 5'(j) < len_ff && !wrap[j]) carry[i] = 1'b0;
         end
      end
      all_wrap = 1'b1;
      for (int j = 0; j < 16; j++) begin
         if (5'(j) < len_ff && !wrap[j]) all_wrap = 1'b0;
      end
   end

   // Classify the request and compute the next odometer state
   always_comb begin
      digits_in = digits_ff;
      len_in    = len_ff;
      exh_in    = exh_ff;
      item.kind   = KIND_TEST;
      item.last   = 1'b0;
      item.len    = len_ff;
      item.digits = digits_ff;
      if (restart) begin
         digits_in   = '0;
         len_in      = eff_start;
         exh_in      = 1'b0;
         item.kind   = KIND_RESTART;
         item.len    = eff_start;
         item.digits = '0;
      end else if (exh_ff) begin
         item.kind = KIND_HELD;
      end else begin
         for (int i = 0; i < 16; i++) begin
            if (5'(i) < len_ff && carry[i]) begin
               digits_in[4 * i +: 4] = wrap[i] ? 4'd0 : digits_ff[4 * i +: 4] + 4'd1;
            end
         end
         if (all_wrap) begin
            if (len_ff < eff_limit) begin
               len_in = len_ff + 5'd1;
            end else begin
               exh_in    = 1'b1;
               item.last = 1'b1;
            end
         end
      end
   end

   // Advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= '0;
         len_ff    <= 5'd1;
         exh_ff    <= 1'b0;
      end else if (accept) begin
         digits_ff <= digits_in;
         len_ff    <= len_in;
         exh_ff    <= exh_in;
      end
   end

endmodule

FILE: rtl/md5ps_fifo.sv
// Short item queue between the front end and the hash back end.
// Uses md5ps_pkg for the item type and depth.
module md5ps_fifo import md5ps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output item_type head_item
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      count_ff;

   assign full      = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_item = mem_ff[rd_ff];

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   // Move pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: rtl/md5ps_back.sv
// Back end: 64-stage MD5 round pipeline, digest compare, found latch and
// the result register. Uses md5ps_pkg.
module md5ps_back import md5ps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  item_type     q_item,
   output logic         q_pop,
   input  logic [63:0]  target_high,
   input  logic [63:0]  target_low,
   input  logic [127:0] chars,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [1:0]   rsp_status,
   output logic [4:0]   rsp_cand_length,
   output logic [63:0]  rsp_cand_digits
);

   logic        st_valid_ff [ROUNDS+1];
   item_type    st_item_ff  [ROUNDS+1];
   logic [31:0] st_a_ff [ROUNDS+1];
   logic [31:0] st_b_ff [ROUNDS+1];
   logic [31:0] st_c_ff [ROUNDS+1];
   logic [31:0] st_d_ff [ROUNDS+1];

   logic        out_valid_ff;
   logic [1:0]  out_status_ff, out_status_in;
   logic [4:0]  out_len_ff, out_len_in;
   logic [63:0] out_digits_ff, out_digits_in;
   logic        found_ff, found_in;
   logic [4:0]  found_len_ff;
   logic [63:0] found_digits_ff;

   logic        en, match;
   logic [31:0] h0, h1, h2, h3;
   item_type    fin;

   assign en    = !out_valid_ff || rsp_pop;
   assign q_pop = en && !q_empty;

   // Load stage zero
   always_ff @(posedge clock) begin
      if (en) begin
         st_item_ff[0] <= q_item;
         st_a_ff[0]    <= IV_A;
         st_b_ff[0]    <= IV_B;
         st_c_ff[0]    <= IV_C;
         st_d_ff[0]    <= IV_D;
      end
   end

   // One MD5 round per stage
   for (genvar gi = 0; gi < ROUNDS; gi++) begin : g_round
      localparam int         RS = md5_shift(gi);
      localparam logic [3:0] RG = md5_index(gi);
      logic [31:0] f, m, sum, rot;
      always_comb begin
         if (gi < 16) begin
            f = (st_b_ff[gi] & st_c_ff[gi]) | (~st_b_ff[gi] & st_d_ff[gi]);
         end else if (gi < 32) begin
            f = (st_d_ff[gi] & st_b_ff[gi]) | (~st_d_ff[gi] & st_c_ff[gi]);
         end else if (gi < 48) begin
            f = st_b_ff[gi] ^ st_c_ff[gi] ^ st_d_ff[gi];
         end else begin
            f = st_c_ff[gi] ^ (st_b_ff[gi] | ~st_d_ff[gi]);
         end
         m   = msg_word(RG, st_item_ff[gi].len, st_item_ff[gi].digits, chars);
         sum = f + st_a_ff[gi] + MD5_K[gi] + m;
         rot = (sum << RS) | (sum >> (32 - RS));
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_item_ff[gi+1] <= st_item_ff[gi];
            st_a_ff[gi+1]    <= st_d_ff[gi];
            st_b_ff[gi+1]    <= st_b_ff[gi] + rot;
            st_c_ff[gi+1]    <= st_b_ff[gi];
            st_d_ff[gi+1]    <= st_c_ff[gi];
         end
      end
   end

   // Finish the digest and compare with the target
   always_comb begin
      fin   = st_item_ff[ROUNDS];
      h0    = st_a_ff[ROUNDS] + IV_A;
      h1    = st_b_ff[ROUNDS] + IV_B;
      h2    = st_c_ff[ROUNDS] + IV_C;
      h3    = st_d_ff[ROUNDS] + IV_D;
      match = ({h0[7:0], h0[15:8], h0[23:16], h0[31:24],
                h1[7:0], h1[15:8], h1[23:16], h1[31:24]} == target_high) &&
              ({h2[7:0], h2[15:8], h2[23:16], h2[31:24],
                h3[7:0], h3[15:8], h3[23:16], h3[31:24]} == target_low);
   end

   // Pick the status; a found candidate overrides later items until restart
   always_comb begin
      found_in      = found_ff;
      out_status_in = ST_IDLE;
      out_len_in    = fin.len;
      out_digits_in = fin.digits;
      case (fin.kind)
         KIND_RESTART: begin
            found_in = 1'b0;
         end
         KIND_TEST: begin
            if (found_ff) begin
               out_len_in    = found_len_ff;
               out_digits_in = found_digits_ff;
            end else if (match) begin
               found_in      = 1'b1;
               out_status_in = ST_FOUND;
            end else begin
               out_status_in = fin.last ? ST_EXHAUSTED : ST_TESTED;
            end
         end
         default: begin
            if (found_ff) begin
               out_len_in    = found_len_ff;
               out_digits_in = found_digits_ff;
            end
         end
      endcase
   end

   // Result register and found candidate
   always_ff @(posedge clock) begin
      if (en && st_valid_ff[ROUNDS]) begin
         out_status_ff <= out_status_in;
         out_len_ff    <= out_len_in;
         out_digits_ff <= out_digits_in;
         if (!found_ff) begin
            found_len_ff    <= fin.len;
            found_digits_ff <= fin.digits;
         end
      end
   end

   // Valid bits and found flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= ROUNDS; s++) st_valid_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else if (en) begin
         st_valid_ff[0] <= !q_empty;
         for (int s = 1; s <= ROUNDS; s++) st_valid_ff[s] <= st_valid_ff[s-1];
         out_valid_ff <= st_valid_ff[ROUNDS];
         if (st_valid_ff[ROUNDS]) found_ff <= found_in;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_cand_length = out_len_ff;
   assign rsp_cand_digits = out_digits_ff;

   // A reported match sets the found flag
   a_found_sets: assert property (@(posedge clock) disable iff (reset)
      (en && st_valid_ff[ROUNDS] && out_status_in == ST_FOUND) |=> found_ff)
      else $error("found flag not set after match");

   // A restart reaching the end clears the found flag
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (en && st_valid_ff[ROUNDS] && fin.kind == KIND_RESTART) |=> !found_ff)
      else $error("found flag survived restart");

   // The last stage always lands in the result register
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (en && st_valid_ff[ROUNDS]) |=> out_valid_ff)
      else $error("pipeline item lost");

   // No second match while one is held
   a_single_found: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !(en && st_valid_ff[ROUNDS] && fin.kind == KIND_RESTART))
      |=> (!out_valid_ff || out_status_ff != ST_FOUND || $stable(out_status_ff) ||
           !$past(en)))
      else $error("match reported while found");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for md5_preimage_search: queue-style driver and monitor,
// with an in-bench MD5 odometer predictor. Depends on rtl/md5ps_pkg.sv and the RTL.
`timescale 1ns / 1ps
module tb_top;
   import md5ps_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  len;
      logic [63:0] digits;
   } cand_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_restart = 1'b0;
   logic        rsp_pop = 1'b0;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_TARGET_HIGH;
   logic [63:0] csr_wdata = '0;
   logic        req_full;
   logic        rsp_empty;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_cand_length;
   logic [63:0] rsp_cand_digits;

   // Search state mirrored by the predictor
   logic [63:0] target_hi, target_lo, chars_lo, chars_hi;
   logic [4:0]  alpha_reg, limit_reg, start_reg;
   logic [3:0]  odo [16];
   logic [4:0]  cur_len;
   logic        found, exhausted;

   bit              pending_restarts [$];
   cand_result_type expected_results [$];
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              hold_left = 0;
   int              fail_count = 0;
   int              cycles = 0;
   int              random_items = 0;

   md5_preimage_search u_dut (.*);

   always #2 clock = ~clock;

   function automatic int clamp(input int v, input int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [7:0] char_at(input logic [3:0] idx);
      return idx[3] ? chars_hi[8 * idx[2:0] +: 8] : chars_lo[8 * idx[2:0] +: 8];
   endfunction

   // MD5 of a candidate (one padded block), digest byte 0 in bits 127..120
   function automatic logic [127:0] cand_digest(input logic [63:0] digs, input int len);
      logic [7:0]  blk [64];
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      logic [31:0] h [4];
      logic [127:0] r;
      int g, s;
      foreach (blk[i]) blk[i] = 8'h00;
      for (int i = 0; i < len; i++) blk[i] = char_at(digs[4 * i +: 4]);
      blk[len] = 8'h80;
      blk[56] = 8'(len * 8);
      for (int i = 0; i < 16; i++)
         m[i] = {blk[4 * i + 3], blk[4 * i + 2], blk[4 * i + 1], blk[4 * i]};
      a = IV_A; b = IV_B; c = IV_C; d = IV_D;
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            f = (b & c) | (~b & d); g = i;
         end else if (i < 32) begin
            f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
         end else if (i < 48) begin
            f = b ^ c ^ d; g = (3 * i + 5) % 16;
         end else begin
            f = c ^ (b | ~d); g = (7 * i) % 16;
         end
         f = f + a + MD5_K[i] + m[g];
         s = MD5_S[((i / 16) * 4) + (i % 4)];
         t = d; d = c; c = b;
         b = b + ((f << s) | (f >> (32 - s)));
         a = t;
      end
      h[0] = a + IV_A; h[1] = b + IV_B; h[2] = c + IV_C; h[3] = d + IV_D;
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = h[i / 4][8 * (i % 4) +: 8];
      return r;
   endfunction

   function automatic logic [63:0] odo_packed();
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < 16; i++) if (i < cur_len) v[4 * i +: 4] = odo[i];
      return v;
   endfunction

   // Apply one transaction to the mirrored search state
   task automatic advance_search(input logic restart, output cand_result_type r);
      logic [127:0] dig;
      int idx;
      if (restart) begin
         foreach (odo[i]) odo[i] = 4'd0;
         cur_len = 5'(clamp(start_reg, clamp(limit_reg, 16)));
         found = 1'b0;
         exhausted = 1'b0;
         r = '{ST_IDLE, cur_len, 64'd0};
      end else if (found || exhausted) begin
         r = '{ST_IDLE, cur_len, odo_packed()};
      end else begin
         r = '{ST_TESTED, cur_len, odo_packed()};
         dig = cand_digest(r.digits, cur_len);
         if (dig == {target_hi, target_lo}) begin
            found = 1'b1;
            r.status = ST_FOUND;
         end else begin
            idx = cur_len - 1;
            while (idx >= 0) begin
               if (odo[idx] + 1 < clamp(alpha_reg, 16)) begin
                  odo[idx] = odo[idx] + 4'd1;
                  break;
               end
               odo[idx] = 4'd0;
               idx--;
            end
            if (idx < 0) begin
               if (cur_len < clamp(limit_reg, 16)) begin
                  cur_len = cur_len + 5'd1;
               end else begin
                  exhausted = 1'b1;
                  r.status = ST_EXHAUSTED;
               end
            end
         end
      end
   endtask

   // Drive one register write; caller closes the burst with end_writes
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_TARGET_HIGH: target_hi = val;
         REG_TARGET_LOW:  target_lo = val;
         REG_CHARS_LOW:   chars_lo = val;
         REG_CHARS_HIGH:  chars_hi = val;
         REG_ALPHABET:    alpha_reg = val[4:0];
         REG_LIMIT:       limit_reg = val[4:0];
         REG_START:       start_reg = val[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
      csr_wdata <= {$urandom, $urandom};
   endtask

   // Point the target at a candidate of the start length that the search can reach
   task automatic aim_target();
      logic [63:0] digs;
      logic [127:0] dig;
      int len;
      len = clamp(start_reg, clamp(limit_reg, 16));
      digs = '0;
      for (int i = 0; i < len; i++) digs[4 * i +: 4] = 4'($urandom_range(clamp(alpha_reg, 16) - 1));
      dig = cand_digest(digs, len);
      write_reg(REG_TARGET_HIGH, dig[127:64]);
      write_reg(REG_TARGET_LOW, dig[63:0]);
   endtask

   // Wait for every queued transaction to be accepted and answered
   task automatic drain();
      while (pending_restarts.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Append one transaction to the pending list
   task automatic enqueue_step(input bit restart);
      pending_restarts = {pending_restarts, restart};
   endtask

   task automatic push_steps(input int n, input int restart_pct);
      for (int i = 0; i < n; i++) enqueue_step($urandom_range(99) < restart_pct);
   endtask

   // Sender: offer the next pending transaction unless idling
   always @(negedge clock) begin
      if (!reset && pending_restarts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         req_push <= 1'b1;
         req_restart <= pending_restarts[0];
      end else begin
         req_push <= 1'b0;
         req_restart <= 1'($urandom_range(1));
      end
   end

   // Receiver: long hold-off when requested, random stalls otherwise
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Accept requests into the predictor and check results
   always @(posedge clock) begin
      cand_result_type r, e;
      cycles <= cycles + 1;
      if (!reset && req_push && !req_full) begin
         advance_search(req_restart, r);
         expected_results = {expected_results, r};
         void'(pending_restarts.pop_front());
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d len=%0d digits=%h", $realtime,
                     rsp_status, rsp_cand_length, rsp_cand_digits);
            fail_count <= fail_count + 1;
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status || rsp_cand_length !== e.len
                || rsp_cand_digits !== e.digits) begin
               $display("%0t: expected status=%0d len=%0d digits=%h, got %0d %0d %h",
                        $realtime, e.status, e.len, e.digits, rsp_status,
                        rsp_cand_length, rsp_cand_digits);
               fail_count <= fail_count + 1;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int phase;
      target_hi = '0; target_lo = '0; chars_lo = '0; chars_hi = '0;
      alpha_reg = 5'd16; limit_reg = 5'd8; start_reg = 5'd1;
      foreach (odo[i]) odo[i] = 4'd0;
      cur_len = 5'd1; found = 1'b0; exhausted = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults after reset
      pending_restarts = '{0, 0, 1, 0};
      drain();
      // Single character alphabet at length one: exhausts at once, then held
      write_reg(REG_CHARS_LOW, '1);
      write_reg(REG_CHARS_HIGH, '1);
      write_reg(REG_TARGET_HIGH, '1);
      write_reg(REG_TARGET_LOW, '1);
      write_reg(REG_ALPHABET, 64'd1);
      write_reg(REG_LIMIT, 64'd1);
      write_reg(REG_START, 64'd1);
      end_writes();
      pending_restarts = '{1, 0, 0};
      drain();
      // Longest candidates, sixteen characters each
      write_reg(REG_CHARS_LOW, {$urandom, $urandom});
      write_reg(REG_ALPHABET, 64'd16);
      write_reg(REG_LIMIT, 64'd16);
      write_reg(REG_START, 64'd16);
      aim_target();
      end_writes();
      pending_restarts = '{1, 0, 0};
      drain();
      // Out-of-range register values are clamped; unused index is ignored
      write_reg(REG_ALPHABET, 64'd0);
      write_reg(REG_LIMIT, 64'd0);
      write_reg(REG_START, 64'd31);
      write_reg(REG_UNUSED, {$urandom, $urandom});
      end_writes();
      pending_restarts = '{1, 0, 0};
      drain();
      write_reg(REG_ALPHABET, 64'd31);
      write_reg(REG_LIMIT, 64'd31);
      write_reg(REG_START, 64'd0);
      end_writes();
      pending_restarts = '{1, 0, 0};
      drain();
      // Three letters up to length two: run past exhaustion
      write_reg(REG_ALPHABET, 64'd3);
      write_reg(REG_LIMIT, 64'd2);
      write_reg(REG_START, 64'd1);
      end_writes();
      enqueue_step(1'b1);
      push_steps(14, 0);
      drain();

      // Random phases: mostly restart-led searches over small spaces
      phase = 0;
      while (random_items < 800) begin
         int n;
         case (phase % 5)
            0, 4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:    begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2:    begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         write_reg(REG_CHARS_LOW, {$urandom, $urandom});
         write_reg(REG_CHARS_HIGH, {$urandom, $urandom});
         case ($urandom_range(5))
            0:       write_reg(REG_ALPHABET, {$urandom, $urandom});
            1:       write_reg(REG_ALPHABET, 64'd16);
            default: write_reg(REG_ALPHABET, 64'($urandom_range(4, 1)));
         endcase
         case ($urandom_range(5))
            0:       write_reg(REG_LIMIT, {$urandom, $urandom});
            default: write_reg(REG_LIMIT, 64'($urandom_range(4, 1)));
         endcase
         write_reg(REG_START, ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                        : 64'($urandom_range(2, 1)));
         if ($urandom_range(1)) begin
            aim_target();
         end else begin
            write_reg(REG_TARGET_HIGH, {$urandom, $urandom});
            write_reg(REG_TARGET_LOW, {$urandom, $urandom});
         end
         end_writes();
         // Enough transactions in the hold-off phase to overflow pipeline and queue
         n = (phase == 3) ? 160 : $urandom_range(60, 20);
         if ($urandom_range(9) < 7) enqueue_step(1'b1);
         push_steps(n, 4);
         if (phase == 3) begin
            // Hold off the receiver so the queue backs up into req_full
            send_idle_pct = 0;
            @(posedge clock);
            hold_left = 300;
         end
         random_items = random_items + n;
         drain();
         phase++;
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: md5_preimage_search.f
rtl/md5ps_pkg.sv
rtl/md5ps_front.sv
rtl/md5ps_fifo.sv
rtl/md5ps_back.sv
rtl/md5_preimage_search.sv
sim/tb_top.sv
